// ===== sv/pia_pkg.sv =====
// Shared constants, codes and types for the positional insert/delete array.
package pia_pkg;

  localparam int DEPTH       = 32;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 6;
  localparam int ACT_W       = 3;
  localparam int STAT_W      = 2;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_DELETE  = 3'd3,
    ACT_DISPLAY = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What a cell stores at the next edge.
  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_LOAD  = 2'd1,
    CM_LEFT  = 2'd2,
    CM_RIGHT = 2'd3
  } cell_mode_t;

endpackage

// ===== sv/pia_cell.sv =====
// One storage cell of the element chain.
module pia_cell (
  input  logic                                clk,
  input  pia_pkg::cell_mode_t                 mode,
  input  logic signed [pia_pkg::DATA_W-1:0]   din,
  input  logic signed [pia_pkg::DATA_W-1:0]   left,
  input  logic signed [pia_pkg::DATA_W-1:0]   right,
  output logic signed [pia_pkg::DATA_W-1:0]   q
);
  import pia_pkg::*;

  always_ff @(posedge clk) begin
    unique case (mode)
      CM_LOAD:  q <= din;
      CM_LEFT:  q <= left;
      CM_RIGHT: q <= right;
      default:  q <= q;
    endcase
  end

endmodule

// ===== sv/pia_ctrl.sv =====
// Request decode, element count, display sequencer and result register.
module pia_ctrl (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [pia_pkg::IN_TDATA_W-1:0]         s_tdata,
  input  logic [pia_pkg::ACT_W-1:0]              s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [pia_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic [pia_pkg::STAT_W-1:0]             m_tuser,
  output logic                                   m_tlast,
  input  logic signed [pia_pkg::DATA_W-1:0]      cell_q [pia_pkg::DEPTH],
  output pia_pkg::cell_mode_t                    mode [pia_pkg::DEPTH],
  output logic signed [pia_pkg::DATA_W-1:0]      din
);
  import pia_pkg::*;

  typedef enum logic {S_IDLE, S_SHOW} state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          remain;
  logic                      out_free;
  logic                      out_load;
  logic                      accept;
  logic                      start_show;
  action_t                   act;
  logic [POS_W-1:0]          pos;
  logic signed [DATA_W-1:0]  val;
  logic [CMP_W-1:0]          posx;
  logic [CMP_W-1:0]          nx;
  logic [CMP_W-1:0]          kx;
  logic                      full;
  logic                      empty;
  status_t                   st;
  logic signed [DATA_W-1:0]  res;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  // result register takes a new entry this cycle
  assign out_load = (state == S_SHOW) ? out_free : (accept && !start_show);

  always_comb begin
    act        = action_t'(s_tuser);
    pos        = s_tdata[POS_W-1:0];
    val        = s_tdata[POS_W +: DATA_W];
    posx       = CMP_W'(pos);
    nx         = CMP_W'(count);
    kx         = posx - CMP_W'(1);
    full       = (count == CNT_W'(DEPTH));
    empty      = (count == '0);
    st         = ST_OK;
    res        = '0;
    count_next = count;
    start_show = 1'b0;
    din        = val;
    for (int j = 0; j < DEPTH; j++) mode[j] = CM_HOLD;

    if (state == S_SHOW) begin
      // rotate the occupied cells down by one; head wraps to the tail
      din = cell_q[0];
      if (out_free) begin
        for (int j = 0; j < DEPTH; j++) begin
          if (CMP_W'(j) + CMP_W'(1) < nx)       mode[j] = CM_RIGHT;
          else if (CMP_W'(j) + CMP_W'(1) == nx) mode[j] = CM_LOAD;
        end
      end
    end else if (accept) begin
      unique case (act)
        ACT_CLEAR: count_next = '0;
        ACT_APPEND: begin
          if (full) st = ST_FULL;
          else begin
            for (int j = 0; j < DEPTH; j++)
              if (CMP_W'(j) == nx) mode[j] = CM_LOAD;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_INSERT: begin
          if (posx == '0 || posx > nx + CMP_W'(1)) st = ST_RANGE;
          else if (full)                         st = ST_FULL;
          else begin
            for (int j = 0; j < DEPTH; j++) begin
              if (CMP_W'(j) == kx)                        mode[j] = CM_LOAD;
              else if (CMP_W'(j) > kx && CMP_W'(j) <= nx) mode[j] = CM_LEFT;
            end
            count_next = count + CNT_W'(1);
          end
        end
        ACT_DELETE: begin
          if (empty)                        st = ST_EMPTY;
          else if (posx == '0 || posx > nx) st = ST_RANGE;
          else begin
            res = cell_q[kx[IDX_W-1:0]];
            for (int j = 0; j < DEPTH; j++)
              if (CMP_W'(j) >= kx && CMP_W'(j) + CMP_W'(1) < nx) mode[j] = CM_RIGHT;
            count_next = count - CNT_W'(1);
          end
        end
        ACT_DISPLAY: begin
          if (empty) st = ST_EMPTY;
          else       start_show = 1'b1;
        end
        default: st = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      remain   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load)                  m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (start_show) begin
              state  <= S_SHOW;
              remain <= count;
            end else begin
              m_tdata  <= OUT_TDATA_W'(unsigned'(res));
              m_tuser  <= st;
              m_tlast  <= 1'b1;
            end
          end
        end
        S_SHOW: begin
          if (out_free) begin
            m_tdata  <= OUT_TDATA_W'(unsigned'(cell_q[0]));
            m_tuser  <= ST_OK;
            m_tlast  <= (remain == CNT_W'(1));
            remain   <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_show_remain: assert property (@(posedge clk) disable iff (rst)
    state == S_SHOW |-> (remain != '0 && remain <= count))
    else $error("display counter out of range");

  a_show_enter: assert property (@(posedge clk) disable iff (rst)
    (accept && act == ACT_DISPLAY && !empty) |=> (state == S_SHOW && !m_tvalid))
    else $error("display did not start");

  a_show_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && $past(state) == S_SHOW) |-> $stable(count))
    else $error("count changed during display");

endmodule

// ===== sv/positional_insert_delete_array_unit.sv =====
// Top level: ordered array of signed elements with positional insert/delete.
//
// Elements live in a chain of DEPTH cells, one element per cell, element 1
// in cell 0. Every cell takes its neighbor's value in the same cycle, so
// clear, append, insert and delete each update the chain at once and give
// one result; a new request is accepted once the result register is free.
// Display of n elements starts, then gives one element per cycle while the
// result register is free, as the occupied cells rotate toward cell 0 and
// the head wraps to the tail; after n steps the array is back in its order.
// Requests are not accepted during display. Status codes: ok, empty,
// position out of range, full. Cell contents are not reset; only cells
// below the element count are ever read.
module positional_insert_delete_array_unit (
  input  logic                              clk,
  input  logic                              rst,
  // request side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pia_pkg::IN_TDATA_W-1:0]    s_tdata,  // position[5:0], value[37:6], zero pad
  input  logic [pia_pkg::ACT_W-1:0]         s_tuser,  // action[2:0]
  // result side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pia_pkg::OUT_TDATA_W-1:0]   m_tdata,  // value_res[31:0]
  output logic [pia_pkg::STAT_W-1:0]        m_tuser,  // status[1:0]
  output logic                              m_tlast   // last
);
  import pia_pkg::*;

  logic signed [DATA_W-1:0] cell_q [DEPTH];
  cell_mode_t               mode   [DEPTH];
  logic signed [DATA_W-1:0] din;

  pia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cell_q   (cell_q),
    .mode     (mode),
    .din      (din)
  );

  // chain ends feed back their own value; those paths are never selected
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    pia_cell u_cell (
      .clk   (clk),
      .mode  (mode[j]),
      .din   (din),
      .left  (cell_q[(j == 0) ? 0 : j - 1]),
      .right (cell_q[(j == DEPTH - 1) ? DEPTH - 1 : j + 1]),
      .q     (cell_q[j])
    );
  end

endmodule

// ===== bench/positional_insert_delete_array_unit_tb.sv =====
// Self-checking bench for the positional insert/delete array: shadow array, result checks.
module positional_insert_delete_array_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pia_pkg::*;

  // Longest run of cycles with no request or result moving before we call it hung.
  localparam int STALL_LIMIT = 2000;

  // One result as the array unit should present it.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic              last;
  } array_result_t;

  // Request mix used by the random traffic: fill up, drain down, or churn.
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} fill_mode_t;

  // Shadow copy of the array plus the queue of results still owed by the unit.
  class array_shadow;
    logic [DATA_W-1:0] cells[$];
    array_result_t     pending[$];
    int                errors;
    int                checked;
    int                peak_fill;
    int                action_seen[1 << ACT_W];
    int                status_seen[1 << STAT_W];

    function void add_result(logic [DATA_W-1:0] value, status_t status, logic last);
      array_result_t r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      pending.push_back(r);
      status_seen[status]++;
    endfunction

    // Called once per accepted request, in acceptance order.
    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
      int n;
      int p;
      n = cells.size();
      p = pos;
      action_seen[act]++;
      case (act)
        ACT_CLEAR: begin
          cells.delete();
          add_result('0, ST_OK, 1'b1);
        end
        ACT_APPEND: begin
          if (n >= DEPTH) begin
            add_result('0, ST_FULL, 1'b1);
          end else begin
            cells.push_back(val);
            add_result('0, ST_OK, 1'b1);
          end
        end
        ACT_INSERT: begin
          // range check wins over the full check
          if (p < 1 || p > n + 1) begin
            add_result('0, ST_RANGE, 1'b1);
          end else if (n >= DEPTH) begin
            add_result('0, ST_FULL, 1'b1);
          end else begin
            cells.insert(p - 1, val);
            add_result('0, ST_OK, 1'b1);
          end
        end
        ACT_DELETE: begin
          // empty array reports empty whatever the position
          if (n == 0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else if (p < 1 || p > n) begin
            add_result('0, ST_RANGE, 1'b1);
          end else begin
            add_result(cells[p - 1], ST_OK, 1'b1);
            cells.delete(p - 1);
          end
        end
        ACT_DISPLAY: begin
          if (n == 0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < n; i++) add_result(cells[i], ST_OK, i == n - 1);
          end
        end
        default: begin
          // spare action codes: no change, one plain ok
          add_result('0, ST_OK, 1'b1);
        end
      endcase
      if (cells.size() > peak_fill) peak_fill = cells.size();
    endfunction

    // Called for every result that leaves the unit.
    function void check_result(logic [DATA_W-1:0] got_value, logic [STAT_W-1:0] got_status,
                               logic got_last);
      array_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display({"%0t: result with nothing outstanding: expected none, ",
                  "got value %0d status %0d last %0b"},
                 $time, $signed(got_value), got_status, got_last);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got_value !== want.value) begin
        errors++;
        $display("%0t: value_res mismatch: expected %0d, actual %0d",
                 $time, $signed(want.value), $signed(got_value));
      end
      if (got_status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got_status);
      end
      if (got_last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got_last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // position[5:0], value[37:6], zero pad
  logic [ACT_W-1:0]       s_tuser = '0;   // action[2:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // value_res[31:0]
  logic [STAT_W-1:0]      m_tuser;        // status[1:0]
  logic                   m_tlast;

  array_shadow shadow = new();
  int          burst_left = 0;
  int          quiet_cycles = 0;

  positional_insert_delete_array_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: every accepted result goes straight to the checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      shadow.check_result(m_tdata[DATA_W-1:0], m_tuser, m_tlast);
  end

  // Hang detector: counts cycles where neither side moves anything.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no traffic for %0d cycles, %0d results still owed",
               $time, STALL_LIMIT, shadow.pending.size());
      $display("positional_insert_delete_array_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result-side backpressure in spans of random length, each in one style:
  // always ready, light random stalls, or mostly stalled.
  initial begin : result_stall
    int style;
    int span;
    forever begin
      style = $urandom_range(0, 2);
      span  = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk);
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 2) != 0);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Present one request from the falling edge, hold it until taken, then
  // maybe drop valid for a gap once the current burst runs out.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({val, pos});
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    shadow.note_request(act, pos, val);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drop valid and sit until every owed result has been seen.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(DATA_W - 1){1'b0}}};
      1: return {1'b0, {(DATA_W - 1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(fill_mode_t mode);
    int      w[5];
    action_t acts[5];
    int      roll;
    acts = '{ACT_APPEND, ACT_INSERT, ACT_DELETE, ACT_DISPLAY, ACT_CLEAR};
    case (mode)
      MODE_GROW:   w = '{50, 38, 6, 5, 0};
      MODE_SHRINK: w = '{10, 8, 60, 14, 3};
      default:     w = '{25, 25, 25, 15, 4};
    endcase
    roll = $urandom_range(0, 99);
    for (int i = 0; i < 5; i++) begin
      if (roll < w[i]) return acts[i];
      roll -= w[i];
    end
    // leftover share goes to the spare codes above display
    return ACT_W'($urandom_range(ACT_DISPLAY + 1, (1 << ACT_W) - 1));
  endfunction

  // Mostly legal positions (ends favored), sometimes anything the field holds.
  function automatic logic [POS_W-1:0] pick_position(logic [ACT_W-1:0] act, int n);
    int top;
    int roll;
    top  = (act == ACT_INSERT) ? n + 1 : n;
    roll = $urandom_range(0, 99);
    if ((act == ACT_INSERT || act == ACT_DELETE) && top >= 1 && roll < 85) begin
      if (roll < 12) return POS_W'(1);
      if (roll < 24) return POS_W'(top);
      return POS_W'($urandom_range(1, top));
    end
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Random traffic in segments of one mix each; spare codes do not count.
  task automatic random_phase(input int total, input bit start_grow);
    fill_mode_t       mode;
    int               seg_left;
    int               done;
    logic [ACT_W-1:0] act;
    done     = 0;
    mode     = MODE_GROW;
    seg_left = start_grow ? 60 : 0;
    while (done < total) begin
      if (seg_left == 0) begin
        mode     = fill_mode_t'($urandom_range(0, 2));
        seg_left = $urandom_range(20, 60);
      end
      act = pick_action(mode);
      send_request(act, pick_position(act, shadow.cells.size()), pick_value());
      seg_left--;
      if (act <= ACT_DISPLAY) done++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-array cases, range edges, extreme values, spare codes.
    send_request(ACT_DISPLAY, '0, '0);                       // display of empty array
    send_request(ACT_DELETE, POS_W'(1), '0);                 // delete from empty array
    send_request(ACT_INSERT, '0, pick_value());              // position zero
    send_request(ACT_INSERT, POS_W'(2), pick_value());       // one past count+1
    send_request(ACT_INSERT, POS_W'(1), {1'b1, {(DATA_W - 1){1'b0}}});
    send_request(ACT_APPEND, '1, {1'b0, {(DATA_W - 1){1'b1}}});
    send_request(ACT_INSERT, POS_W'(3), '0);                 // insert at the tail
    send_request(ACT_INSERT, POS_W'(2), '1);                 // insert in the middle
    send_request(ACT_DISPLAY, '1, '1);
    send_request(ACT_DELETE, '0, '1);                        // position zero
    send_request(ACT_DELETE, POS_W'(5), '0);                 // one past count
    send_request(ACT_DELETE, '1, '0);                        // top of the field
    send_request(ACT_INSERT, '1, pick_value());              // top of the field
    send_request(ACT_DELETE, POS_W'(4), '0);                 // remove last
    send_request(ACT_DELETE, POS_W'(1), '0);                 // remove first
    for (int a = ACT_DISPLAY + 1; a < (1 << ACT_W); a++)
      send_request(ACT_W'(a), POS_W'($urandom), DATA_W'($urandom));
    send_request(ACT_DISPLAY, '0, '0);
    send_request(ACT_CLEAR, '1, '1);
    send_request(ACT_DISPLAY, '0, '0);
    send_request(ACT_APPEND, '1, 32'h5555_5555);
    send_request(ACT_CLEAR, '0, '0);

    // Random traffic; first segment fills the array to hit the full cases.
    random_phase(200, 1'b1);
    wait_drained();
    repeat ($urandom_range(5, 40)) @(negedge clk);
    random_phase(200, 1'b1);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display({"Requests: clear %0d, append %0d, insert %0d, delete %0d, display %0d; ",
              "%0d results checked"},
             shadow.action_seen[ACT_CLEAR], shadow.action_seen[ACT_APPEND],
             shadow.action_seen[ACT_INSERT], shadow.action_seen[ACT_DELETE],
             shadow.action_seen[ACT_DISPLAY], shadow.checked);
    $display("Peak fill %0d of %0d; empty %0d, out of range %0d, full %0d status results",
             shadow.peak_fill, DEPTH, shadow.status_seen[ST_EMPTY],
             shadow.status_seen[ST_RANGE], shadow.status_seen[ST_FULL]);
    if (shadow.errors == 0) begin
      $display("positional_insert_delete_array_unit_tb OK");
    end else begin
      $display("positional_insert_delete_array_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
